>>> src/avad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avad_pkg
// Shared types and constants for the adaptive voice activity detector.
// ----------------------------------------------------------------------------
package avad_pkg;

	localparam int NumCh        = 2;
	localparam int ChW          = $clog2(NumCh);
	localparam int HistDepthDef = 16;
	localparam int BlockLenDef  = 128;
	localparam int MaxFrameDef  = 4096;
	localparam int QueueDepth   = 2;

	// widest frame record fields over the whole parameter range
	localparam int AbsSumMaxW = 32;
	localparam int FrameMaxW  = 17;

	localparam logic [1:0] RegMinThreshold  = 2'd0;
	localparam logic [1:0] RegSensitivity   = 2'd1;
	localparam logic [1:0] RegChannelsInUse = 2'd2;

	localparam logic [15:0] MinThresholdRst = 16'd655;
	localparam logic [15:0] SensitivityRst  = 16'd16384;
	localparam logic [1:0]  ChannelsRst     = 2'd1;

	// background factor is 2.5 - sensitivity, in Q15
	localparam logic [16:0] FactorBase = 17'd81920;

	typedef struct packed {
		logic [15:0] min_threshold;
		logic [15:0] sensitivity;
		logic [1:0]  channels_in_use;
	} cfg_t;

	typedef struct packed {
		logic [NumCh-1:0][AbsSumMaxW-1:0] abs_sum;
		logic [NumCh-1:0][15:0]           bg;
		logic [FrameMaxW-1:0]             n;
	} frame_rec_t;

endpackage

>>> src/avad_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avad_front
// Per-sample accumulation of frame and block magnitude sums; emits one frame
// record at each frame end.
// ----------------------------------------------------------------------------
module avad_front #(
	parameter int BLOCK_LEN = avad_pkg::BlockLenDef,
	parameter int MAX_FRAME = avad_pkg::MaxFrameDef
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [15:0]       sample_a,
	input  logic signed [15:0]       sample_b,
	input  logic                     last_of_frame,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     queue_full,
	output logic                     push,
	output avad_pkg::frame_rec_t     push_rec
);

	localparam int FCW = $clog2(MAX_FRAME + 1);
	localparam int ASW = 16 + $clog2(MAX_FRAME);
	localparam int LBL = $clog2(BLOCK_LEN);
	localparam int BW  = 16 + LBL;

	logic [FCW-1:0] fc_q;
	logic [ASW-1:0] abs_q [avad_pkg::NumCh];
	logic [BW-1:0]  blk_q [avad_pkg::NumCh];
	logic [BW-1:0]  min_q [avad_pkg::NumCh];
	logic           full_seen_q;

	logic [15:0]    mag      [avad_pkg::NumCh];
	logic [ASW-1:0] abs_next [avad_pkg::NumCh];
	logic [BW-1:0]  blk_next [avad_pkg::NumCh];
	logic [BW-1:0]  min_next [avad_pkg::NumCh];
	logic [BW-1:0]  bg_src   [avad_pkg::NumCh];
	logic [FCW-1:0] n;
	logic           block_done;
	logic           full_next;
	logic           frame_end;
	logic           accept;

	assign in_stall   = queue_full;
	assign accept     = in_valid && !in_stall;
	assign n          = fc_q + FCW'(1);
	assign block_done = (n[LBL-1:0] == '0);
	assign full_next  = full_seen_q || block_done;
	assign frame_end  = last_of_frame || (n >= FCW'(MAX_FRAME));
	assign push       = accept && frame_end;

	assign mag[0] = sample_a[15] ? 16'(~sample_a + 16'd1) : sample_a;
	assign mag[1] = sample_b[15] ? 16'(~sample_b + 16'd1) : sample_b;

	always_comb begin
		for (int c = 0; c < avad_pkg::NumCh; c++) begin
			abs_next[c] = abs_q[c] + ASW'(mag[c]);
			blk_next[c] = blk_q[c] + BW'(mag[c]);
			if (block_done && (!full_seen_q || blk_next[c] < min_q[c])) begin
				min_next[c] = blk_next[c];
			end else begin
				min_next[c] = min_q[c];
			end
			bg_src[c] = full_next ? min_next[c] : blk_next[c];
			push_rec.abs_sum[c] = avad_pkg::AbsSumMaxW'(abs_next[c]);
			push_rec.bg[c]      = 16'(bg_src[c] >> LBL);
		end
		push_rec.n = avad_pkg::FrameMaxW'(n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q        <= '0;
			full_seen_q <= 1'b0;
			for (int c = 0; c < avad_pkg::NumCh; c++) begin
				abs_q[c] <= '0;
				blk_q[c] <= '0;
				min_q[c] <= '0;
			end
		end else if (accept) begin
			if (frame_end) begin
				fc_q        <= '0;
				full_seen_q <= 1'b0;
				for (int c = 0; c < avad_pkg::NumCh; c++) begin
					abs_q[c] <= '0;
					blk_q[c] <= '0;
					min_q[c] <= '0;
				end
			end else begin
				fc_q        <= n;
				full_seen_q <= full_next;
				for (int c = 0; c < avad_pkg::NumCh; c++) begin
					abs_q[c] <= abs_next[c];
					blk_q[c] <= block_done ? '0 : blk_next[c];
					min_q[c] <= min_next[c];
				end
			end
		end
	end

endmodule

>>> src/avad_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avad_queue
// Small register queue of frame records between the front and back ends.
// ----------------------------------------------------------------------------
module avad_queue #(
	parameter int DEPTH = avad_pkg::QueueDepth
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  avad_pkg::frame_rec_t push_rec,
	output logic                 full,
	input  logic                 pop,
	output avad_pkg::frame_rec_t head,
	output logic                 empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	avad_pkg::frame_rec_t mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

>>> src/avad_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avad_back
// Frame-end decision: threshold and history tests per channel, history
// update and result register.
// ----------------------------------------------------------------------------
module avad_back #(
	parameter int HISTORY_DEPTH = avad_pkg::HistDepthDef,
	parameter int MAX_FRAME     = avad_pkg::MaxFrameDef
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  avad_pkg::cfg_t       cfg,
	input  logic                 empty,
	input  avad_pkg::frame_rec_t head,
	output logic                 pop,
	output logic                 active,
	output logic [15:0]          background_a,
	output logic [15:0]          background_b,
	output logic                 out_valid,
	input  logic                 out_stall
);

	localparam int FCW = $clog2(MAX_FRAME + 1);
	localparam int ASW = 16 + $clog2(MAX_FRAME);
	localparam int HW  = 16 + $clog2(HISTORY_DEPTH);
	localparam int IW  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int TW  = 16 + FCW;
	localparam int FW  = 17 + FCW;
	localparam int RW  = HW + FW;
	localparam int LW  = ASW + 15 + $clog2(HISTORY_DEPTH) + 1;
	localparam int CMW = (LW > RW) ? LW : RW;
	localparam int LhsScale = HISTORY_DEPTH * 32768;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_CMP,
		ST_WRITE
	} state_t;

	state_t               state_q;
	avad_pkg::frame_rec_t rec_q;
	logic [avad_pkg::ChW-1:0] ch_q;
	logic [TW-1:0]        t1_q;
	logic [FW-1:0]        fn_q;
	logic [RW-1:0]        rhs_q;
	logic                 act_q;
	logic [15:0]          hist_q [avad_pkg::NumCh][HISTORY_DEPTH];
	logic [HW-1:0]        hsum_q [avad_pkg::NumCh];
	logic [IW-1:0]        idx_q;
	logic                 out_valid_q;
	logic                 active_q;
	logic [15:0]          bg_a_q;
	logic [15:0]          bg_b_q;

	logic                 two_ch;
	logic [avad_pkg::ChW-1:0] last_ch;
	logic [FCW-1:0]       n;
	logic [16:0]          factor;
	logic [ASW-1:0]       abs_cur;
	logic [LW-1:0]        lhs;
	logic                 hit;

	// zero acts as one channel, three as two
	assign two_ch  = (cfg.channels_in_use[1] == 1'b1) && (avad_pkg::NumCh >= 2);
	assign last_ch = two_ch ? avad_pkg::ChW'(1) : '0;
	assign n       = FCW'(rec_q.n);
	assign factor  = avad_pkg::FactorBase - {1'b0, cfg.sensitivity};
	assign abs_cur = ASW'(rec_q.abs_sum[ch_q]);
	assign lhs     = LW'(abs_cur) * LW'(LhsScale);
	assign hit     = (TW'(abs_cur) > t1_q && abs_cur <= ASW'({TW{1'b1}})) ||
		(ASW > TW && abs_cur > ASW'({TW{1'b1}})) ||
		(CMW'(lhs) > CMW'(rhs_q));
	assign pop     = (state_q == ST_IDLE) && !empty;

	assign active       = active_q;
	assign background_a = bg_a_q;
	assign background_b = bg_b_q;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rec_q       <= '0;
			ch_q        <= '0;
			t1_q        <= '0;
			fn_q        <= '0;
			rhs_q       <= '0;
			act_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			active_q    <= 1'b0;
			bg_a_q      <= '0;
			bg_b_q      <= '0;
			for (int c = 0; c < avad_pkg::NumCh; c++) begin
				hsum_q[c] <= '0;
				for (int k = 0; k < HISTORY_DEPTH; k++) begin
					hist_q[c][k] <= '0;
				end
			end
		end else begin
			// the write state loads the next beat itself
			if (out_valid_q && !out_stall && state_q != ST_WRITE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!empty) begin
						rec_q   <= head;
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					t1_q    <= TW'(cfg.min_threshold) * TW'(n);
					fn_q    <= FW'(factor) * FW'(n);
					ch_q    <= '0;
					act_q   <= 1'b0;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					rhs_q   <= RW'(hsum_q[ch_q]) * RW'(fn_q);
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					act_q <= act_q || hit;
					if (ch_q == last_ch) begin
						state_q <= ST_WRITE;
					end else begin
						ch_q    <= ch_q + avad_pkg::ChW'(1);
						state_q <= ST_MUL2;
					end
				end
				ST_WRITE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						active_q    <= act_q;
						bg_a_q      <= rec_q.bg[0];
						bg_b_q      <= two_ch ? rec_q.bg[1] : 16'd0;
						for (int c = 0; c < avad_pkg::NumCh; c++) begin
							if (c == 0 || two_ch) begin
								hist_q[c][idx_q] <= rec_q.bg[c];
								hsum_q[c] <= hsum_q[c] + HW'(rec_q.bg[c]) -
									HW'(hist_q[c][idx_q]);
							end
						end
						idx_q   <= (idx_q == IW'(HISTORY_DEPTH - 1)) ? '0 : idx_q + IW'(1);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/adaptive_voice_activity_detect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_voice_activity_detect
// Energy-based voice activity detector for two Q15 channels with an
// adaptive background history.
//
//   port group   direction  handshake            payload
//   input        in         in_valid / in_stall  sample_a, sample_b, last_of_frame
//   result       out        out_valid/out_stall  active, background_a, background_b
//   config       in         cfg_we               cfg_index, cfg_data
//
// The front end takes one sample beat per cycle. A frame end is queued and
// judged by the back end (ST_MUL1, then ST_MUL2 and ST_CMP for each
// channel against the running history sums), then held in the result
// register. Input stalls only while the frame record queue is full.
// Reset clears all sums and the background history at once; no clearing pass.
// BLOCK_LEN must be a power of two.
// ----------------------------------------------------------------------------
module adaptive_voice_activity_detect #(
	parameter int HISTORY_DEPTH = avad_pkg::HistDepthDef,
	parameter int BLOCK_LEN     = avad_pkg::BlockLenDef,
	parameter int MAX_FRAME     = avad_pkg::MaxFrameDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] sample_a,
	input  logic signed [15:0] sample_b,
	input  logic               last_of_frame,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               active,
	output logic [15:0]        background_a,
	output logic [15:0]        background_b,
	output logic               out_valid,
	input  logic               out_stall,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	avad_pkg::cfg_t       cfg_q;
	avad_pkg::frame_rec_t push_rec;
	avad_pkg::frame_rec_t head;
	logic                 push;
	logic                 pop;
	logic                 queue_full;
	logic                 queue_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_threshold   <= avad_pkg::MinThresholdRst;
			cfg_q.sensitivity     <= avad_pkg::SensitivityRst;
			cfg_q.channels_in_use <= avad_pkg::ChannelsRst;
		end else if (cfg_we) begin
			case (cfg_index)
				avad_pkg::RegMinThreshold:  cfg_q.min_threshold   <= cfg_data;
				avad_pkg::RegSensitivity:   cfg_q.sensitivity     <= cfg_data;
				avad_pkg::RegChannelsInUse: cfg_q.channels_in_use <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	avad_front #(
		.BLOCK_LEN (BLOCK_LEN),
		.MAX_FRAME (MAX_FRAME)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_a      (sample_a),
		.sample_b      (sample_b),
		.last_of_frame (last_of_frame),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.queue_full    (queue_full),
		.push          (push),
		.push_rec      (push_rec)
	);

	avad_queue #(
		.DEPTH (avad_pkg::QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.full     (queue_full),
		.pop      (pop),
		.head     (head),
		.empty    (queue_empty)
	);

	avad_back #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.MAX_FRAME     (MAX_FRAME)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.empty        (queue_empty),
		.head         (head),
		.pop          (pop),
		.active       (active),
		.background_a (background_a),
		.background_b (background_b),
		.out_valid    (out_valid),
		.out_stall    (out_stall)
	);

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the adaptive voice activity detector: directed
// frames, then random frames of mixed loudness and length under several
// register settings, with random idling on both sides and a long output
// hold-off; every frame verdict is checked against a local predictor or a typed verdict.
// ----------------------------------------------------------------------------
module tb;

	localparam int HistDepth = 16;
	localparam int BlockLen  = 128;
	localparam int MaxFrame  = 4096;
	localparam int IdleLimit = 4000;

	typedef struct {
		logic        active;
		logic [15:0] bg_a;
		logic [15:0] bg_b;
	} verdict_t;

	typedef struct {
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic               last;
		logic               typed;
		verdict_t           v;
	} beat_row_t;

	logic               clk = 0;
	logic               arst_n = 0;
	logic signed [15:0] sample_a = 0;
	logic signed [15:0] sample_b = 0;
	logic               last_of_frame = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic               active;
	logic [15:0]        background_a;
	logic [15:0]        background_b;
	logic               out_valid;
	logic               out_stall = 1;
	logic               cfg_we = 0;
	logic [1:0]         cfg_index = avad_pkg::RegMinThreshold;
	logic [15:0]        cfg_data = 0;

	adaptive_voice_activity_detect uut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// predictor state
	longint unsigned thr_q, sens_q, chan_q;
	longint unsigned frame_len, ring_pos;
	longint unsigned energy[2], blk_energy[2], blk_floor[2];
	longint unsigned bg_hist[2][HistDepth];
	bit              got_block;

	verdict_t verdicts_q[$];
	int       mismatches = 0;
	int       frames_seen = 0, active_seen = 0, beats_sent = 0;
	bit       calm = 0, hold_req = 0;
	int       idle_cycles = 0;

	// returns 1 and fills v when the beat closes a frame
	function automatic bit vad_step(input logic signed [15:0] a, input logic signed [15:0] b,
			input logic last, output verdict_t v);
		longint unsigned n, hsum, s, bgv[2];
		longint          sv[2];
		int              nch;
		bit              blk, act;
		n = frame_len + 1;
		sv[0] = a;
		sv[1] = b;
		blk = (n % BlockLen) == 0;
		for (int c = 0; c < 2; c++) begin
			s = sv[c] < 0 ? -sv[c] : sv[c];
			energy[c] += s;
			blk_energy[c] += s;
			if (blk && (!got_block || blk_energy[c] < blk_floor[c]))
				blk_floor[c] = blk_energy[c];
		end
		if (blk) begin
			got_block = 1;
			blk_energy[0] = 0;
			blk_energy[1] = 0;
		end
		if (!last && n < MaxFrame) begin
			frame_len = n;
			return 0;
		end
		nch = (chan_q == 0) ? 1 : (chan_q == 3) ? 2 : int'(chan_q);
		act = 0;
		for (int c = 0; c < nch && !act; c++) begin
			hsum = 0;
			for (int k = 0; k < HistDepth; k++)
				hsum += bg_hist[c][k];
			if (energy[c] > thr_q * n ||
					energy[c] * HistDepth * 32768 > hsum * (81920 - sens_q) * n)
				act = 1;
		end
		for (int c = 0; c < 2; c++)
			bgv[c] = ((got_block ? blk_floor[c] : blk_energy[c]) / BlockLen) & 16'hFFFF;
		for (int c = 0; c < nch; c++)
			bg_hist[c][ring_pos] = bgv[c];
		ring_pos = (ring_pos + 1) % HistDepth;
		v.active = act;
		v.bg_a = bgv[0];
		v.bg_b = nch >= 2 ? bgv[1] : 0;
		frame_len = 0;
		for (int c = 0; c < 2; c++) begin
			energy[c] = 0;
			blk_energy[c] = 0;
			blk_floor[c] = 0;
		end
		got_block = 0;
		return 1;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		case (idx)
			avad_pkg::RegMinThreshold:  thr_q = val;
			avad_pkg::RegSensitivity:   sens_q = val;
			avad_pkg::RegChannelsInUse: chan_q = val[1:0];
			default: ;
		endcase
	endtask

	// typed verdict, when given, replaces the predicted one
	task automatic send_beat(input logic signed [15:0] a, input logic signed [15:0] b,
			input logic last, input bit typed, input verdict_t tv);
		verdict_t v;
		int       gap;
		gap = calm ? 0 : $urandom_range(0, 7);
		in_valid = 0;
		repeat (gap) @(negedge clk);
		sample_a = a;
		sample_b = b;
		last_of_frame = last;
		in_valid = 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		beats_sent++;
		if (vad_step(a, b, last, v))
			verdicts_q.push_back(typed ? tv : v);
		@(negedge clk);
		in_valid = 0;
	endtask

	function automatic logic signed [15:0] pick_sample(input int loud);
		case (loud)
			0: return $urandom_range(0, 400) - 200;
			1: return $urandom_range(0, 1) ? 16'sh8000 + $urandom_range(0, 2000)
				: 16'sh7fff - $urandom_range(0, 2000);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_frame(input int len, input bit mark);
		verdict_t nv;
		int       loud;
		loud = $urandom_range(0, 2);
		for (int i = 0; i < len; i++)
			send_beat(pick_sample(loud), pick_sample(loud), mark && i == len - 1, 0, nv);
	endtask

	task automatic drain;
		wait (verdicts_q.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	// result side: random hold-off per verdict, long hold on request
	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			w = calm ? 0 : $urandom_range(0, 7);
			if (hold_req)
				w = 300;
			@(negedge clk);
			out_stall = 1;
			repeat (w) @(negedge clk);
			hold_req = 0;
			out_stall = 0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		verdict_t e;
		if (out_valid && !out_stall) begin
			frames_seen++;
			if (verdicts_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: active=%0d bg_a=%0d bg_b=%0d",
						active, background_a, background_b);
			end else begin
				e = verdicts_q.pop_front();
				active_seen += e.active;
				if (e.active !== active || e.bg_a !== background_a
						|| e.bg_b !== background_b) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
							e.active, e.bg_a, e.bg_b, active, background_a, background_b);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("watchdog expired");
			$display("Verification failed");
			$finish;
		end
	end

	beat_row_t rows[] = '{
		'{16'sd0, 16'sd0, 1, 1, '{0, 16'd0, 16'd0}},
		'{-16'sd32768, 16'sd32767, 1, 1, '{1, 16'd256, 16'd0}},
		'{16'sd32767, -16'sd32768, 0, 0, '{0, 0, 0}},
		'{-16'sd1, 16'sd1, 1, 0, '{0, 0, 0}},
		'{16'sd1, -16'sd1, 1, 0, '{0, 0, 0}},
		'{16'sd0, 16'sd0, 1, 0, '{0, 0, 0}},
		'{16'sd655, 16'sd0, 1, 0, '{0, 0, 0}},
		'{16'sd656, 16'sd0, 1, 0, '{0, 0, 0}},
		'{-16'sd21846, 16'sh5555, 0, 0, '{0, 0, 0}},
		'{16'sh5555, -16'sd21846, 1, 0, '{0, 0, 0}},
		'{-16'sd32768, -16'sd32768, 1, 0, '{0, 0, 0}},
		'{16'sd2, 16'sd2, 1, 0, '{0, 0, 0}}
	};

	initial begin
		logic [15:0] thr_set[5];
		logic [15:0] sens_set[5];
		logic [1:0]  ch_set[5];
		thr_set = '{16'd0, 16'd32768, 16'd65535, 16'd300, 16'd32768};
		sens_set = '{16'd0, 16'd32768, 16'd65535, 16'd16384, 16'd0};
		ch_set = '{2'd2, 2'd3, 2'd0, 2'd1, 2'd2};
		thr_q = avad_pkg::MinThresholdRst;
		sens_q = avad_pkg::SensitivityRst;
		chan_q = avad_pkg::ChannelsRst;
		frame_len = 0;
		ring_pos = 0;
		got_block = 0;
		for (int c = 0; c < 2; c++) begin
			energy[c] = 0;
			blk_energy[c] = 0;
			blk_floor[c] = 0;
			for (int k = 0; k < HistDepth; k++)
				bg_hist[c][k] = 0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		foreach (rows[i])
			send_beat(rows[i].a, rows[i].b, rows[i].last, rows[i].typed, rows[i].v);
		send_frame(260, 1);
		drain();

		for (int p = 0; p < 5; p++) begin
			if (p == 3) begin
				thr_set[p] = $urandom_range(0, 32768);
				sens_set[p] = $urandom;
			end
			write_reg(avad_pkg::RegMinThreshold, thr_set[p]);
			write_reg(avad_pkg::RegSensitivity, sens_set[p]);
			write_reg(avad_pkg::RegChannelsInUse, ch_set[p]);
			calm = (p == 1);
			for (int f = 0; f < 5; f++)
				send_frame($urandom_range(0, 5) == 0 ? $urandom_range(129, 400)
					: $urandom_range(1, 40), 1);
			if (p == 4) begin
				// long output hold while short frames keep arriving
				calm = 1;
				hold_req = 1;
				for (int f = 0; f < 30; f++)
					send_frame(1, 1);
				calm = 0;
			end
			drain();
		end

		$display("%0d beats sent, %0d frames judged (%0d active) over 6 register settings",
			beats_sent, frames_seen, active_seen);
		if (mismatches == 0 && verdicts_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> sim.f
src/avad_pkg.sv
src/avad_front.sv
src/avad_queue.sv
src/avad_back.sv
src/adaptive_voice_activity_detect.sv
tb/tb.sv
